>>> sv/lfupa_pkg.sv
// Shared types and constants for the lowest-free unit pool allocator.
package lfupa_pkg;

	localparam int ARR_W  = 31;
	localparam int NEED_W = 8;
	localparam int HOLD_W = 16;
	localparam int REL_W  = 32;
	localparam int SUM_W  = 14;
	localparam int CFG_W  = 8;

	localparam logic [CFG_W-1:0] SC_RESET = 8'd128;

	// Kind of walk the token is making down the chain
	typedef enum logic {
		PASS_FREE,
		PASS_GRANT
	} pass_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FREE,
		ST_GRANT,
		ST_DONE
	} state_t;

	// Request data broadcast to every cell
	typedef struct packed {
		logic [ARR_W-1:0] arrival;
		logic [REL_W-1:0] end_m1;
		logic             do_set;
		pass_t            kind;
	} bcast_t;

endpackage

>>> sv/lfupa_cell.sv
// One pool unit: taken flag and release time, plus one stage of the walking token.
module lfupa_cell #(
	parameter int IDX = 0,
	parameter int CW  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lfupa_pkg::bcast_t              bc,
	input  logic [CW-1:0]                  units,
	input  logic                           tok_i,
	input  logic [CW-1:0]                  acc_i,
	input  logic [lfupa_pkg::SUM_W-1:0]    sum_i,
	output logic                           tok_o,
	output logic [CW-1:0]                  acc_o,
	output logic [lfupa_pkg::SUM_W-1:0]    sum_o
);

	logic                          taken_q;
	logic [lfupa_pkg::REL_W-1:0]   rel_q;
	logic                          tok_q;
	logic [CW-1:0]                 acc_q;
	logic [lfupa_pkg::SUM_W-1:0]   sum_q;

	logic                          in_pool;
	logic                          expired;
	logic                          free_after;
	logic                          take;
	logic [CW-1:0]                 acc_d;
	logic [lfupa_pkg::SUM_W-1:0]   sum_d;

	// per-unit decisions for the word passing through
	always_comb begin
		in_pool    = units > CW'(IDX);
		expired    = {1'b0, bc.arrival} > rel_q;
		free_after = !taken_q || expired;
		take       = 1'b0;
		acc_d      = acc_i;
		sum_d      = sum_i;
		case (bc.kind)
			lfupa_pkg::PASS_FREE: begin
				if (in_pool && free_after)
					acc_d = acc_i + CW'(1);
			end
			lfupa_pkg::PASS_GRANT: begin
				take = in_pool && !taken_q && (acc_i != '0);
				if (take) begin
					acc_d = acc_i - CW'(1);
					sum_d = sum_i + lfupa_pkg::SUM_W'(IDX + 1);
				end
			end
			default: ;
		endcase
	end

	// unit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= 1'b0;
		end else if (tok_i) begin
			if (bc.kind == lfupa_pkg::PASS_FREE)
				taken_q <= !free_after;
			else if (take && bc.do_set)
				taken_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_i && take && bc.do_set)
			rel_q <= bc.end_m1;
	end

	// hand the token on to the next unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_i;
		end
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		sum_q <= sum_d;
	end

	assign tok_o = tok_q;
	assign acc_o = acc_q;
	assign sum_o = sum_q;

endmodule

>>> sv/lowest_free_unit_pool_allocator.sv
// Pool allocator top: request controller driving a chain of unit cells.
// For each accepted request, a token walks the chain of MAX_UNITS cells once
// to expire old holds and count the free units, then (unless the request is
// rejected or asks for no units) a second time to grant the lowest-numbered
// free units and add up their numbers. Each walk advances one cell per cycle.
// One request is in work at a time; the result sits in an output register, so
// a new request may be accepted while the previous result waits. Units beyond
// server_count (capped at MAX_UNITS) are never granted. The configuration word
// is taken in any cycle.
module lowest_free_unit_pool_allocator #(
	parameter int MAX_UNITS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // arrival_time[30:0], units_needed[38:31], hold_time[54:39]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // rejected[0], id_sum[14:1]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // server_count
);

	localparam int CW = $clog2(MAX_UNITS + 1);
	localparam int PW = (CW > lfupa_pkg::NEED_W) ? CW : lfupa_pkg::NEED_W;

	lfupa_pkg::state_t             state_q, state_d;
	logic [lfupa_pkg::CFG_W-1:0]   sc_q;
	logic [lfupa_pkg::ARR_W-1:0]   arr_q;
	logic [lfupa_pkg::NEED_W-1:0]  need_q;
	logic [lfupa_pkg::REL_W-1:0]   endm1_q;
	logic                          set_q;
	lfupa_pkg::pass_t              kind_q;
	logic                          head_tok_q;
	logic [CW-1:0]                 head_acc_q;
	logic                          res_rej_q;
	logic [lfupa_pkg::SUM_W-1:0]   res_sum_q;
	logic                          m_tvalid_q;
	logic [15:0]                   m_tdata_q;

	logic                          s_fire;
	logic [lfupa_pkg::ARR_W-1:0]   in_arr;
	logic [lfupa_pkg::NEED_W-1:0]  in_need;
	logic [lfupa_pkg::HOLD_W-1:0]  in_hold;
	logic [lfupa_pkg::REL_W-1:0]   in_end;
	logic [PW-1:0]                 sc_ext;
	logic [CW-1:0]                 units;
	lfupa_pkg::bcast_t             bc;

	logic                          launch;
	lfupa_pkg::pass_t              launch_kind;
	logic [CW-1:0]                 launch_acc;
	logic                          fin;
	logic                          fin_rej;
	logic [lfupa_pkg::SUM_W-1:0]   fin_sum;
	logic                          out_load;

	logic                          tok_w [0:MAX_UNITS];
	logic [CW-1:0]                 acc_w [0:MAX_UNITS];
	logic [lfupa_pkg::SUM_W-1:0]   sum_w [0:MAX_UNITS];
	logic [MAX_UNITS:0]            tok_vec;

	assign in_arr  = s_tdata[30:0];
	assign in_need = s_tdata[38:31];
	assign in_hold = s_tdata[54:39];
	assign in_end  = {1'b0, in_arr} + lfupa_pkg::REL_W'(in_hold);

	assign s_tready  = (state_q == lfupa_pkg::ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// active pool size, capped at the number of cells
	assign sc_ext = PW'(sc_q);
	assign units  = (sc_ext < PW'(MAX_UNITS)) ? CW'(sc_ext) : CW'(MAX_UNITS);

	assign bc.arrival = arr_q;
	assign bc.end_m1  = endm1_q;
	assign bc.do_set  = set_q;
	assign bc.kind    = kind_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= lfupa_pkg::SC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sc_q <= cfg_data;
		end
	end

	// controller next state and pass sequencing
	always_comb begin
		state_d     = state_q;
		launch      = 1'b0;
		launch_kind = lfupa_pkg::PASS_FREE;
		launch_acc  = '0;
		fin         = 1'b0;
		fin_rej     = 1'b0;
		fin_sum     = '0;
		out_load    = 1'b0;
		unique case (state_q)
			lfupa_pkg::ST_IDLE: begin
				if (s_fire) begin
					launch  = 1'b1;
					state_d = lfupa_pkg::ST_FREE;
				end
			end
			lfupa_pkg::ST_FREE: begin
				if (tok_w[MAX_UNITS]) begin
					if (PW'(acc_w[MAX_UNITS]) < PW'(need_q)) begin
						fin     = 1'b1;
						fin_rej = 1'b1;
						state_d = lfupa_pkg::ST_DONE;
					end else if (need_q == '0) begin
						fin     = 1'b1;
						state_d = lfupa_pkg::ST_DONE;
					end else begin
						launch      = 1'b1;
						launch_kind = lfupa_pkg::PASS_GRANT;
						launch_acc  = CW'(need_q);
						state_d     = lfupa_pkg::ST_GRANT;
					end
				end
			end
			lfupa_pkg::ST_GRANT: begin
				if (tok_w[MAX_UNITS]) begin
					fin     = 1'b1;
					fin_sum = sum_w[MAX_UNITS];
					state_d = lfupa_pkg::ST_DONE;
				end
			end
			lfupa_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = lfupa_pkg::ST_IDLE;
				end
			end
			default: state_d = lfupa_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lfupa_pkg::ST_IDLE;
			head_tok_q <= 1'b0;
			kind_q     <= lfupa_pkg::PASS_FREE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_tok_q <= launch;
			if (launch)
				kind_q <= launch_kind;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			arr_q   <= in_arr;
			need_q  <= in_need;
			endm1_q <= in_end - lfupa_pkg::REL_W'(1);
			set_q   <= (in_end != '0);
		end
		head_acc_q <= launch_acc;
		if (fin) begin
			res_rej_q <= fin_rej;
			res_sum_q <= fin_sum;
		end
		if (out_load)
			m_tdata_q <= {1'b0, res_sum_q, res_rej_q};
	end

	// chain of unit cells
	assign tok_w[0] = head_tok_q;
	assign acc_w[0] = head_acc_q;
	assign sum_w[0] = '0;

	for (genvar i = 0; i < MAX_UNITS; i++) begin : g_cell
		lfupa_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bc     (bc),
			.units  (units),
			.tok_i  (tok_w[i]),
			.acc_i  (acc_w[i]),
			.sum_i  (sum_w[i]),
			.tok_o  (tok_w[i+1]),
			.acc_o  (acc_w[i+1]),
			.sum_o  (sum_w[i+1])
		);
	end

	for (genvar j = 0; j <= MAX_UNITS; j++) begin : g_tokvec
		assign tok_vec[j] = tok_w[j];
	end

	// at most one token walks the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one token in the unit chain");

	// the token leaves the chain only during a walk
	a_tail_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		tok_w[MAX_UNITS] |-> (state_q == lfupa_pkg::ST_FREE ||
			state_q == lfupa_pkg::ST_GRANT))
		else $error("token left the chain outside a walk");

	// a grant walk hands out every unit asked for
	a_grant_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_w[MAX_UNITS] && state_q == lfupa_pkg::ST_GRANT) |-> acc_w[MAX_UNITS] == '0)
		else $error("grant walk ended with units still owed");

	// a rejected word carries no unit numbers
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> m_tdata[14:1] == '0)
		else $error("rejected word has a nonzero sum");

endmodule
